// ===== hw/rtl/cpec_pkg.sv =====
`default_nettype none
package cpec_pkg;

  localparam int POS_W = 20;
  localparam int VEL_W = 16;
  localparam int RAD_W = 16;

  typedef enum logic [1:0] {
    OC_NONE       = 2'd0,
    OC_COINCIDENT = 2'd1,
    OC_SEPARATED  = 2'd2,
    OC_IMPULSE    = 2'd3
  } outcome_t;

  typedef struct packed {
    logic signed [POS_W-1:0] a_pos_x;
    logic signed [POS_W-1:0] a_pos_y;
    logic signed [VEL_W-1:0] a_vel_x;
    logic signed [VEL_W-1:0] a_vel_y;
    logic        [RAD_W-1:0] a_radius;
    logic signed [POS_W-1:0] b_pos_x;
    logic signed [POS_W-1:0] b_pos_y;
    logic signed [VEL_W-1:0] b_vel_x;
    logic signed [VEL_W-1:0] b_vel_y;
    logic        [RAD_W-1:0] b_radius;
  } pair_t;

  typedef struct packed {
    outcome_t                outcome;
    logic signed [POS_W-1:0] new_a_pos_x;
    logic signed [POS_W-1:0] new_a_pos_y;
    logic signed [VEL_W-1:0] new_a_vel_x;
    logic signed [VEL_W-1:0] new_a_vel_y;
    logic signed [POS_W-1:0] new_b_pos_x;
    logic signed [POS_W-1:0] new_b_pos_y;
    logic signed [VEL_W-1:0] new_b_vel_x;
    logic signed [VEL_W-1:0] new_b_vel_y;
  } result_t;

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [POS_W+1:0] v);
    logic signed [POS_W-1:0] r;
    if (v > $signed((POS_W+2)'({1'b0, {(POS_W-1){1'b1}}}))) begin
      r = {1'b0, {(POS_W-1){1'b1}}};
    end else if (v < $signed((POS_W+2)'(-(2**(POS_W-1))))) begin
      r = {1'b1, {(POS_W-1){1'b0}}};
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [VEL_W+3:0] v);
    logic signed [VEL_W-1:0] r;
    if (v > $signed((VEL_W+4)'({1'b0, {(VEL_W-1){1'b1}}}))) begin
      r = {1'b0, {(VEL_W-1){1'b1}}};
    end else if (v < $signed((VEL_W+4)'(-(2**(VEL_W-1))))) begin
      r = {1'b1, {(VEL_W-1){1'b0}}};
    end else begin
      r = v[VEL_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/circle_pair_elastic_collision_unit.sv =====
`default_nettype none
// Throughput: one pair per cycle; busy stays low, results cannot be held off.
// Most of the depth comes from the 25-stage square-root array and the 17-stage separation divider.
// Synchronous reset clears the valid bits only; payload stages are not reset.
module circle_pair_elastic_collision_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  cpec_pkg::pair_t    pair,
  output logic               done,
  output cpec_pkg::result_t  result
);
  import cpec_pkg::*;

  localparam int SQ_STEPS  = 25;
  localparam int IMP_STEPS = 18;
  localparam int SH_STEPS  = 17;

  typedef struct packed {
    pair_t        pair;
    logic         contact;
    logic         zero;
    logic         sep;
    logic         sgx;
    logic         sgy;
    logic [16:0]  rs;
    logic [16:0]  adx;
    logic [16:0]  ady;
    logic [50:0]  rem;
    logic [24:0]  root;
    logic [54:0]  inx;
    logic [54:0]  iny;
    logic [34:0]  iden;
    logic [17:0]  iqx;
    logic [17:0]  iqy;
  } lp_t;

  typedef struct packed {
    pair_t               pair;
    logic                contact;
    logic                zero;
    logic                sep;
    logic                sgx;
    logic                sgy;
    logic [16:0]         adx;
    logic [16:0]         ady;
    logic [24:0]         gap;
    logic [24:0]         root;
    logic signed [18:0]  ix;
    logic signed [18:0]  iy;
  } mid_t;

  typedef struct packed {
    pair_t               pair;
    logic                contact;
    logic                zero;
    logic                sep;
    logic                sgx;
    logic                sgy;
    logic signed [18:0]  ix;
    logic signed [18:0]  iy;
    logic [42:0]         nx;
    logic [42:0]         ny;
    logic [25:0]         den;
    logic [16:0]         qx;
    logic [16:0]         qy;
  } sd_t;

  assign busy = 1'b0;

  // front stages
  logic               a_vld;
  pair_t              a_pair;
  logic               b_vld;
  pair_t              b_pair;
  logic signed [20:0] b_dx, b_dy;
  logic signed [16:0] b_dvx, b_dvy;
  logic [16:0]        b_rs;
  logic               c_vld;
  pair_t              c_pair;
  logic               c_near;
  logic signed [35:0] c_sqx, c_sqy;
  logic [33:0]        c_rsq;
  logic signed [34:0] c_px, c_py;
  logic signed [17:0] c_dx18, c_dy18;
  logic [16:0]        c_rs;
  logic               d_vld;
  pair_t              d_pair;
  logic               d_contact, d_zero, d_sep, d_sgx, d_sgy;
  logic [35:0]        d_pm;
  logic [33:0]        d_d2;
  logic [16:0]        d_adx, d_ady, d_rs;
  logic               e_vld;
  pair_t              e_pair;
  logic               e_contact, e_zero, e_sep, e_sgx, e_sgy;
  logic [52:0]        e_nx, e_ny;
  logic [33:0]        e_d2;
  logic [16:0]        e_adx, e_ady, e_rs;

  logic signed [17:0] dx18, dy18, adx18, ady18;
  logic               near;
  logic [36:0]        d2_w;
  logic signed [35:0] p_w;

  assign dx18  = b_dx[17:0];
  assign dy18  = b_dy[17:0];
  assign near  = ((b_dx[20:17] == 4'b0000) || (b_dx[20:17] == 4'b1111)) &&
                 ((b_dy[20:17] == 4'b0000) || (b_dy[20:17] == 4'b1111));
  assign d2_w  = {1'b0, c_sqx} + {1'b0, c_sqy};
  assign p_w   = 36'(c_px) + 36'(c_py);
  assign adx18 = c_dx18[17] ? -c_dx18 : c_dx18;
  assign ady18 = c_dy18[17] ? -c_dy18 : c_dy18;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
      c_vld <= 1'b0;
      d_vld <= 1'b0;
      e_vld <= 1'b0;
    end else begin
      a_vld <= start;
      b_vld <= a_vld;
      c_vld <= b_vld;
      d_vld <= c_vld;
      e_vld <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    a_pair <= pair;

    b_pair <= a_pair;
    b_dx   <= 21'(a_pair.b_pos_x) - 21'(a_pair.a_pos_x);
    b_dy   <= 21'(a_pair.b_pos_y) - 21'(a_pair.a_pos_y);
    b_dvx  <= 17'(a_pair.b_vel_x) - 17'(a_pair.a_vel_x);
    b_dvy  <= 17'(a_pair.b_vel_y) - 17'(a_pair.a_vel_y);
    b_rs   <= 17'(a_pair.a_radius) + 17'(a_pair.b_radius);

    c_pair <= b_pair;
    c_near <= near;
    c_sqx  <= dx18 * dx18;
    c_sqy  <= dy18 * dy18;
    c_rsq  <= b_rs * b_rs;
    c_px   <= b_dvx * dx18;
    c_py   <= b_dvy * dy18;
    c_dx18 <= dx18;
    c_dy18 <= dy18;
    c_rs   <= b_rs;

    d_pair    <= c_pair;
    d_contact <= c_near && (d2_w < {3'b000, c_rsq});
    d_zero    <= (d2_w == 37'd0);
    d_sep     <= !p_w[35] && (p_w != 36'sd0);
    d_pm      <= 36'(-p_w);
    d_d2      <= d2_w[33:0];
    d_adx     <= adx18[16:0];
    d_ady     <= ady18[16:0];
    d_sgx     <= c_dx18[17];
    d_sgy     <= c_dy18[17];
    d_rs      <= c_rs;

    e_pair    <= d_pair;
    e_contact <= d_contact;
    e_zero    <= d_zero;
    e_sep     <= d_sep;
    e_sgx     <= d_sgx;
    e_sgy     <= d_sgy;
    e_nx      <= d_pm * d_adx;
    e_ny      <= d_pm * d_ady;
    e_d2      <= d_d2;
    e_adx     <= d_adx;
    e_ady     <= d_ady;
    e_rs      <= d_rs;
  end

  // square root and impulse division, one result bit per stage
  lp_t  lp [0:SQ_STEPS];
  logic lv [0:SQ_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      lv[0] <= 1'b0;
    end else begin
      lv[0] <= e_vld;
    end
  end

  always_ff @(posedge clk) begin
    lp[0].pair    <= e_pair;
    lp[0].contact <= e_contact;
    lp[0].zero    <= e_zero;
    lp[0].sep     <= e_sep;
    lp[0].sgx     <= e_sgx;
    lp[0].sgy     <= e_sgy;
    lp[0].rs      <= e_rs;
    lp[0].adx     <= e_adx;
    lp[0].ady     <= e_ady;
    lp[0].rem     <= 51'({e_d2, 16'h0000});
    lp[0].root    <= '0;
    lp[0].inx     <= 55'({e_nx, 1'b0}) + 55'(e_d2);
    lp[0].iny     <= 55'({e_ny, 1'b0}) + 55'(e_d2);
    lp[0].iden    <= {e_d2, 1'b0};
    lp[0].iqx     <= '0;
    lp[0].iqy     <= '0;
  end

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
    localparam int SI = SQ_STEPS - 1 - k;
    logic [50:0] trial;
    logic [54:0] nx_n, ny_n;
    logic [17:0] qx_n, qy_n;
    lp_t         nxt;

    if (k < IMP_STEPS) begin : g_div
      localparam int DI = IMP_STEPS - 1 - k;
      logic [54:0] dsh;
      assign dsh  = 55'(lp[k].iden) << DI;
      assign nx_n = (lp[k].inx >= dsh) ? lp[k].inx - dsh : lp[k].inx;
      assign ny_n = (lp[k].iny >= dsh) ? lp[k].iny - dsh : lp[k].iny;
      assign qx_n = (lp[k].inx >= dsh) ? lp[k].iqx | (18'(1) << DI) : lp[k].iqx;
      assign qy_n = (lp[k].iny >= dsh) ? lp[k].iqy | (18'(1) << DI) : lp[k].iqy;
    end else begin : g_hold
      assign nx_n = lp[k].inx;
      assign ny_n = lp[k].iny;
      assign qx_n = lp[k].iqx;
      assign qy_n = lp[k].iqy;
    end

    always_comb begin
      nxt   = lp[k];
      trial = (51'(lp[k].root) << (SI + 1)) + (51'(1) << (2 * SI));
      if (lp[k].rem >= trial) begin
        nxt.rem  = lp[k].rem - trial;
        nxt.root = lp[k].root | (25'(1) << SI);
      end
      nxt.inx = nx_n;
      nxt.iny = ny_n;
      nxt.iqx = qx_n;
      nxt.iqy = qy_n;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        lv[k+1] <= 1'b0;
      end else begin
        lv[k+1] <= lv[k];
      end
    end

    always_ff @(posedge clk) begin
      lp[k+1] <= nxt;
    end
  end

  // overlap and separation numerators
  logic        g_vld, h_vld;
  mid_t        g, h;
  logic [41:0] h_gx, h_gy;
  lp_t         lq;

  assign lq = lp[SQ_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      g_vld <= 1'b0;
      h_vld <= 1'b0;
    end else begin
      g_vld <= lv[SQ_STEPS];
      h_vld <= g_vld;
    end
  end

  always_ff @(posedge clk) begin
    g.pair    <= lq.pair;
    g.contact <= lq.contact;
    g.zero    <= lq.zero;
    g.sep     <= lq.sep;
    g.sgx     <= lq.sgx;
    g.sgy     <= lq.sgy;
    g.adx     <= lq.adx;
    g.ady     <= lq.ady;
    g.gap     <= {lq.rs, 8'h00} - lq.root;
    g.root    <= lq.root;
    g.ix      <= lq.sgx ? -$signed(19'(lq.iqx)) : $signed(19'(lq.iqx));
    g.iy      <= lq.sgy ? -$signed(19'(lq.iqy)) : $signed(19'(lq.iqy));

    h    <= g;
    h_gx <= g.gap * g.adx;
    h_gy <= g.gap * g.ady;
  end

  // separation division
  sd_t  sd [0:SH_STEPS];
  logic sv [0:SH_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      sv[0] <= 1'b0;
    end else begin
      sv[0] <= h_vld;
    end
  end

  always_ff @(posedge clk) begin
    sd[0].pair    <= h.pair;
    sd[0].contact <= h.contact;
    sd[0].zero    <= h.zero;
    sd[0].sep     <= h.sep;
    sd[0].sgx     <= h.sgx;
    sd[0].sgy     <= h.sgy;
    sd[0].ix      <= h.ix;
    sd[0].iy      <= h.iy;
    sd[0].nx      <= 43'(h_gx) + 43'(h.root);
    sd[0].ny      <= 43'(h_gy) + 43'(h.root);
    sd[0].den     <= {h.root, 1'b0};
    sd[0].qx      <= '0;
    sd[0].qy      <= '0;
  end

  for (genvar k = 0; k < SH_STEPS; k++) begin : g_sh
    localparam int DI = SH_STEPS - 1 - k;
    logic [42:0] dsh;
    sd_t         nxt;

    assign dsh = 43'(sd[k].den) << DI;

    always_comb begin
      nxt = sd[k];
      if (sd[k].nx >= dsh) begin
        nxt.nx = sd[k].nx - dsh;
        nxt.qx = sd[k].qx | (17'(1) << DI);
      end
      if (sd[k].ny >= dsh) begin
        nxt.ny = sd[k].ny - dsh;
        nxt.qy = sd[k].qy | (17'(1) << DI);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sv[k+1] <= 1'b0;
      end else begin
        sv[k+1] <= sv[k];
      end
    end

    always_ff @(posedge clk) begin
      sd[k+1] <= nxt;
    end
  end

  // apply and saturate
  sd_t                sf;
  logic signed [17:0] sx, sy;
  result_t            result_next;

  assign sf = sd[SH_STEPS];
  assign sx = sf.sgx ? -$signed(18'(sf.qx)) : $signed(18'(sf.qx));
  assign sy = sf.sgy ? -$signed(18'(sf.qy)) : $signed(18'(sf.qy));

  always_comb begin
    result_next.outcome     = OC_NONE;
    result_next.new_a_pos_x = sf.pair.a_pos_x;
    result_next.new_a_pos_y = sf.pair.a_pos_y;
    result_next.new_a_vel_x = sf.pair.a_vel_x;
    result_next.new_a_vel_y = sf.pair.a_vel_y;
    result_next.new_b_pos_x = sf.pair.b_pos_x;
    result_next.new_b_pos_y = sf.pair.b_pos_y;
    result_next.new_b_vel_x = sf.pair.b_vel_x;
    result_next.new_b_vel_y = sf.pair.b_vel_y;
    priority if (!sf.contact) begin
      result_next.outcome = OC_NONE;
    end else if (sf.zero) begin
      result_next.outcome = OC_COINCIDENT;
    end else begin
      result_next.new_a_pos_x = sat_pos(22'(sf.pair.a_pos_x) - 22'(sx));
      result_next.new_a_pos_y = sat_pos(22'(sf.pair.a_pos_y) - 22'(sy));
      result_next.new_b_pos_x = sat_pos(22'(sf.pair.b_pos_x) + 22'(sx));
      result_next.new_b_pos_y = sat_pos(22'(sf.pair.b_pos_y) + 22'(sy));
      if (sf.sep) begin
        result_next.outcome = OC_SEPARATED;
      end else begin
        result_next.outcome     = OC_IMPULSE;
        result_next.new_a_vel_x = sat_vel(20'(sf.pair.a_vel_x) - 20'(sf.ix));
        result_next.new_a_vel_y = sat_vel(20'(sf.pair.a_vel_y) - 20'(sf.iy));
        result_next.new_b_vel_x = sat_vel(20'(sf.pair.b_vel_x) + 20'(sf.ix));
        result_next.new_b_vel_y = sat_vel(20'(sf.pair.b_vel_y) + 20'(sf.iy));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= sv[SH_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

  a_sqrt_floor: assert property (@(posedge clk) disable iff (rst)
    (lv[SQ_STEPS] && lq.contact) |-> (lq.rem <= 51'({lq.root, 1'b0})))
    else $error("square root remainder out of range");

  a_imp_rem: assert property (@(posedge clk) disable iff (rst)
    (lv[IMP_STEPS] && lp[IMP_STEPS].contact && !lp[IMP_STEPS].zero &&
     !lp[IMP_STEPS].sep) |-> (lp[IMP_STEPS].inx < 55'(lp[IMP_STEPS].iden)))
    else $error("impulse quotient overflow");

  a_sep_rem: assert property (@(posedge clk) disable iff (rst)
    (sv[SH_STEPS] && sf.contact && !sf.zero) |-> (sf.nx < 43'(sf.den)))
    else $error("separation quotient overflow");

  a_no_contact: assert property (@(posedge clk) disable iff (rst)
    (sv[SH_STEPS] && !sf.contact) |=>
      (done && (result.outcome == OC_NONE) &&
       (result.new_a_pos_x == $past(sf.pair.a_pos_x)) &&
       (result.new_b_vel_y == $past(sf.pair.b_vel_y))))
    else $error("pair without contact altered");

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import cpec_pkg::*;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  logic    busy;
  pair_t   pair = '0;
  logic    done;
  result_t result;

  pair_t   pending_pairs[$];
  result_t expected_results[$];
  int      gap_left = 0;
  int      failures = 0;
  bit      stimulus_done = 1'b0;
  bit      hold_for_drain = 1'b0;

  circle_pair_elastic_collision_unit uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .pair(pair), .done(done), .result(result)
  );

  always #1 clk = ~clk;

  function automatic longint isqrt(input longint v);
    longint r, b;
    r = 0;
    b = 64'sd1 <<< 62;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic longint round_div(input longint num, input longint den);
    longint m, q;
    m = (num < 0) ? -num : num;
    q = (2 * m + den) / (2 * den);
    return (num < 0) ? -q : q;
  endfunction

  function automatic longint clamp(input longint v, input int w);
    longint hi;
    hi = (64'sd1 <<< (w - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic result_t collide(input pair_t p);
    result_t r;
    longint apx, apy, bpx, bpy, avx, avy, bvx, bvy;
    longint dx, dy, d2, rs, root_d, gap, sx, sy, dot, ix, iy;
    apx = p.a_pos_x; apy = p.a_pos_y; bpx = p.b_pos_x; bpy = p.b_pos_y;
    avx = p.a_vel_x; avy = p.a_vel_y; bvx = p.b_vel_x; bvy = p.b_vel_y;
    r.outcome = OC_NONE;
    r.new_a_pos_x = p.a_pos_x; r.new_a_pos_y = p.a_pos_y;
    r.new_b_pos_x = p.b_pos_x; r.new_b_pos_y = p.b_pos_y;
    r.new_a_vel_x = p.a_vel_x; r.new_a_vel_y = p.a_vel_y;
    r.new_b_vel_x = p.b_vel_x; r.new_b_vel_y = p.b_vel_y;
    dx = bpx - apx;
    dy = bpy - apy;
    d2 = dx * dx + dy * dy;
    rs = longint'(p.a_radius) + longint'(p.b_radius);
    if (d2 >= rs * rs) return r;
    if (d2 == 0) begin
      r.outcome = OC_COINCIDENT;
      return r;
    end
    root_d = isqrt(d2 <<< 16);
    gap = rs * 256 - root_d;
    sx = round_div(gap * dx, 2 * root_d);
    sy = round_div(gap * dy, 2 * root_d);
    r.new_a_pos_x = POS_W'(clamp(apx - sx, POS_W));
    r.new_a_pos_y = POS_W'(clamp(apy - sy, POS_W));
    r.new_b_pos_x = POS_W'(clamp(bpx + sx, POS_W));
    r.new_b_pos_y = POS_W'(clamp(bpy + sy, POS_W));
    dot = (bvx - avx) * dx + (bvy - avy) * dy;
    if (dot > 0) begin
      r.outcome = OC_SEPARATED;
      return r;
    end
    ix = round_div(-dot * dx, d2);
    iy = round_div(-dot * dy, d2);
    r.new_a_vel_x = VEL_W'(clamp(avx - ix, VEL_W));
    r.new_a_vel_y = VEL_W'(clamp(avy - iy, VEL_W));
    r.new_b_vel_x = VEL_W'(clamp(bvx + ix, VEL_W));
    r.new_b_vel_y = VEL_W'(clamp(bvy + iy, VEL_W));
    r.outcome = OC_IMPULSE;
    return r;
  endfunction

  function automatic int pick_gap();
    int k;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 70);
  endfunction

  function automatic pair_t random_pair();
    pair_t p;
    int mode, span;
    p = $bits(pair_t)'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    mode = $urandom_range(0, 9);
    if (mode < 7) begin
      span = (mode < 3) ? 255 : (mode < 5) ? 8191 : 131071;
      p.a_radius = RAD_W'($urandom_range(0, span));
      p.b_radius = RAD_W'($urandom_range(0, span));
      p.b_pos_x = POS_W'(p.a_pos_x + $signed(20'($urandom_range(0, 2 * span))) - span);
      p.b_pos_y = POS_W'(p.a_pos_y + $signed(20'($urandom_range(0, 2 * span))) - span);
      if ($urandom_range(0, 19) == 0) p.b_pos_x = p.a_pos_x;
      if ($urandom_range(0, 19) == 0) p.b_pos_y = p.a_pos_y;
    end else if (mode == 7) begin
      p.b_pos_x = p.a_pos_x;
      p.b_pos_y = p.a_pos_y;
    end
    return p;
  endfunction

  task automatic add_pair(input pair_t p);
    pending_pairs.push_back(p);
  endtask

  task automatic directed_pairs();
    pair_t p;
    p = '0;
    add_pair(p);
    p.a_radius = 16'hFFFF; p.b_radius = 16'hFFFF;
    add_pair(p);
    p.a_vel_x = 16'sh7FFF; p.b_vel_x = -16'sh8000;
    p.b_pos_x = 20'sd256;
    add_pair(p);
    p.a_pos_x = 20'sh7FFFF; p.b_pos_x = 20'sh7FF00; p.a_pos_y = -20'sh80000;
    p.b_pos_y = -20'sh7FF00;
    add_pair(p);
    p.a_pos_x = -20'sh80000; p.b_pos_x = -20'sh7FF00; p.a_pos_y = 20'sh7FFFF;
    p.b_pos_y = 20'sh7FF00; p.a_vel_x = -16'sh8000; p.b_vel_x = 16'sh7FFF;
    p.a_vel_y = 16'sh7FFF; p.b_vel_y = -16'sh8000;
    add_pair(p);
    p = '0; p.a_radius = 16'd256; p.b_radius = 16'd256; p.b_pos_x = 20'sd512;
    add_pair(p);
    p.b_pos_x = 20'sd300; p.a_vel_x = 16'sd100; p.b_vel_x = 16'sd100;
    add_pair(p);
    p.a_vel_x = 16'sd0; p.b_vel_x = 16'sd50;
    add_pair(p);
    p.a_vel_y = 16'sd77; p.b_vel_y = -16'sd33; p.b_pos_y = 20'sd100;
    add_pair(p);
    p.a_radius = 16'd1; p.b_radius = 16'd0; p.b_pos_x = 20'sd0; p.b_pos_y = 20'sd0;
    add_pair(p);
    p.a_radius = 16'd0; p.b_pos_x = 20'sd1;
    add_pair(p);
    p.a_radius = 16'd2; p.b_pos_x = -20'sd1;
    add_pair(p);
    p = '1;
    add_pair(p);
  endtask

  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_results.push_back(collide(pair));
      end
      if (start && busy) begin
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (hold_for_drain || pending_pairs.size() == 0) begin
        start <= 1'b0;
      end else begin
        pair <= pending_pairs.pop_front();
        start <= 1'b1;
        gap_left <= pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $error("result with no pending pair");
        failures++;
      end else begin
        result_t e;
        e = expected_results.pop_front();
        if (result.outcome !== e.outcome) begin
          $error("outcome exp %0d got %0d", e.outcome, result.outcome); failures++;
        end
        if (result.new_a_pos_x !== e.new_a_pos_x) begin
          $error("new_a_pos_x exp %0d got %0d", e.new_a_pos_x, result.new_a_pos_x);
          failures++;
        end
        if (result.new_a_pos_y !== e.new_a_pos_y) begin
          $error("new_a_pos_y exp %0d got %0d", e.new_a_pos_y, result.new_a_pos_y);
          failures++;
        end
        if (result.new_a_vel_x !== e.new_a_vel_x) begin
          $error("new_a_vel_x exp %0d got %0d", e.new_a_vel_x, result.new_a_vel_x);
          failures++;
        end
        if (result.new_a_vel_y !== e.new_a_vel_y) begin
          $error("new_a_vel_y exp %0d got %0d", e.new_a_vel_y, result.new_a_vel_y);
          failures++;
        end
        if (result.new_b_pos_x !== e.new_b_pos_x) begin
          $error("new_b_pos_x exp %0d got %0d", e.new_b_pos_x, result.new_b_pos_x);
          failures++;
        end
        if (result.new_b_pos_y !== e.new_b_pos_y) begin
          $error("new_b_pos_y exp %0d got %0d", e.new_b_pos_y, result.new_b_pos_y);
          failures++;
        end
        if (result.new_b_vel_x !== e.new_b_vel_x) begin
          $error("new_b_vel_x exp %0d got %0d", e.new_b_vel_x, result.new_b_vel_x);
          failures++;
        end
        if (result.new_b_vel_y !== e.new_b_vel_y) begin
          $error("new_b_vel_y exp %0d got %0d", e.new_b_vel_y, result.new_b_vel_y);
          failures++;
        end
      end
    end
  end

  initial begin
    directed_pairs();
    for (int i = 0; i < 600; i++) add_pair(random_pair());
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    wait (pending_pairs.size() == 0);
    @(negedge clk);
    hold_for_drain = 1'b1;
    @(posedge clk);
    wait (expected_results.size() == 0);
    for (int i = 0; i < 600; i++) add_pair(random_pair());
    @(negedge clk);
    hold_for_drain = 1'b0;
    wait (pending_pairs.size() == 0);
    @(negedge clk);
    @(negedge clk);
    stimulus_done = 1'b1;
  end

  initial begin
    wait (stimulus_done);
    wait (expected_results.size() == 0);
    repeat (80) @(posedge clk);
    if (failures == 0 && expected_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("Test completed with failures");
    $finish;
  end
endmodule
